[src/ssfi_pkg.sv]
package ssfi_pkg;

    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRAPOLATE_ON = 1'd1;

    localparam logic [7:0] JUMP_RESET = 8'd16;
    localparam logic [7:0] OFFSCREEN_X = 8'd168;
    localparam logic [7:0] OFFSCREEN_Y = 8'd160;

    localparam logic signed [9:0] WRAP_HALF = 10'sd128;
    localparam logic signed [9:0] WRAP_FULL = 10'sd256;

    localparam logic [9:0] ONE_Q8 = 10'd256;
    localparam logic signed [20:0] ROUND_HALF = 21'sd128;

    localparam logic CMD_SPRITE = 1'b0;
    localparam logic CMD_SCROLL = 1'b1;

    typedef struct packed {
        logic       command;
        logic       prev_valid;
        logic [8:0] alpha;
        logic [7:0] prev_x;
        logic [7:0] prev_y;
        logic [7:0] prev_tile;
        logic [7:0] prev_attr;
        logic [7:0] cur_x;
        logic [7:0] cur_y;
        logic [7:0] cur_tile;
        logic [7:0] cur_attr;
    } t_in;

    typedef struct packed {
        logic [7:0] out_x;
        logic [7:0] out_y;
        logic [7:0] out_tile;
        logic [7:0] out_attr;
    } t_out;

    typedef struct packed {
        logic              interp;
        logic signed [9:0] dx;
        logic signed [9:0] dy;
    } t_gate;

endpackage

[src/ssfi_gate.sv]
module ssfi_gate (
    input  ssfi_pkg::t_in   i_item,
    input  logic [7:0]      i_thr,
    output ssfi_pkg::t_gate o_gate
);

    logic signed [9:0] dx_raw;
    logic signed [9:0] dy_raw;
    logic signed [9:0] dx_wrap;
    logic signed [9:0] dy_wrap;
    logic signed [9:0] dx_neg;
    logic signed [9:0] dy_neg;
    logic [7:0]        dx_abs;
    logic [7:0]        dy_abs;
    logic              prev_off;
    logic              cur_off;
    logic              same_look;
    logic              sprite_ok;

    assign dx_raw = signed'({2'b00, i_item.cur_x}) - signed'({2'b00, i_item.prev_x});
    assign dy_raw = signed'({2'b00, i_item.cur_y}) - signed'({2'b00, i_item.prev_y});

    // fold scroll deltas into -128..128, the short way around the wrap
    always_comb begin
        dx_wrap = dx_raw;
        if (dx_raw > ssfi_pkg::WRAP_HALF) begin
            dx_wrap = dx_raw - ssfi_pkg::WRAP_FULL;
        end else if (dx_raw < -ssfi_pkg::WRAP_HALF) begin
            dx_wrap = dx_raw + ssfi_pkg::WRAP_FULL;
        end
        dy_wrap = dy_raw;
        if (dy_raw > ssfi_pkg::WRAP_HALF) begin
            dy_wrap = dy_raw - ssfi_pkg::WRAP_FULL;
        end else if (dy_raw < -ssfi_pkg::WRAP_HALF) begin
            dy_wrap = dy_raw + ssfi_pkg::WRAP_FULL;
        end
    end

    assign dx_neg = -dx_raw;
    assign dy_neg = -dy_raw;
    assign dx_abs = dx_raw[9] ? dx_neg[7:0] : dx_raw[7:0];
    assign dy_abs = dy_raw[9] ? dy_neg[7:0] : dy_raw[7:0];

    assign prev_off = (i_item.prev_y == 8'd0) || (i_item.prev_y >= ssfi_pkg::OFFSCREEN_Y)
                   || (i_item.prev_x == 8'd0) || (i_item.prev_x >= ssfi_pkg::OFFSCREEN_X);
    assign cur_off  = (i_item.cur_y == 8'd0) || (i_item.cur_y >= ssfi_pkg::OFFSCREEN_Y)
                   || (i_item.cur_x == 8'd0) || (i_item.cur_x >= ssfi_pkg::OFFSCREEN_X);

    assign same_look = (i_item.prev_tile == i_item.cur_tile)
                    && (i_item.prev_attr == i_item.cur_attr);
    assign sprite_ok = same_look && !prev_off && !cur_off
                    && (dx_abs <= i_thr) && (dy_abs <= i_thr);

    always_comb begin
        if (i_item.command == ssfi_pkg::CMD_SCROLL) begin
            o_gate.interp = i_item.prev_valid;
            o_gate.dx     = dx_wrap;
            o_gate.dy     = dy_wrap;
        end else begin
            o_gate.interp = i_item.prev_valid && sprite_ok;
            o_gate.dx     = dx_raw;
            o_gate.dy     = dy_raw;
        end
    end

endmodule

[src/ssfi_blend.sv]
module ssfi_blend (
    input  logic [7:0]        i_base,
    input  logic signed [9:0] i_delta,
    input  logic [9:0]        i_t,
    output logic [7:0]        o_val
);

    logic signed [20:0] prod;
    logic signed [20:0] rounded;

    // base*256 only lands in the upper byte, so add it after the shift
    assign prod    = 21'(i_delta) * 21'(signed'({1'b0, i_t}));
    assign rounded = prod + ssfi_pkg::ROUND_HALF;
    assign o_val   = i_base + rounded[15:8];

endmodule

[src/sprite_scroll_frame_interpolator_unit.sv]
// Sprite/scroll frame interpolator. One transaction per clock: an item is
// taken on every edge where start is high and busy is low (busy is high only
// while reset is held); it passes the input register, then the blend stage
// and the result register, and appears on o_out with o_done high for exactly
// one cycle. The receiver cannot stall, so o_out is valid only in the o_done
// cycle; capture it there. While busy is low, items stream back to back with
// a sustained rate of one per cycle (one 10x10 signed multiply per axis in
// the single blend stage between the two registers). Write configuration
// only while no transaction is in flight: index 0 is the jump threshold
// (reset 16), index 1 enables extrapolation (t = 1 + alpha).
module sprite_scroll_frame_interpolator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ssfi_pkg::t_in                       i_in,
    output logic                                o_done,
    output ssfi_pkg::t_out                      o_out,
    input  logic                                i_cfg_we,
    input  logic [ssfi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ssfi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    ssfi_pkg::t_in   r_in;
    logic            r_in_vld;
    logic [7:0]      r_thr;
    logic            r_ext;
    ssfi_pkg::t_out  r_out;
    logic            r_out_vld;

    ssfi_pkg::t_out  n_out;
    ssfi_pkg::t_gate gate;
    logic [9:0]      t_fac;
    logic [7:0]      blend_x;
    logic [7:0]      blend_y;
    logic            accept;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ssfi_pkg::JUMP_RESET;
            r_ext <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssfi_pkg::CFG_JUMP_THRESHOLD: r_thr <= i_cfg_data[7:0];
                ssfi_pkg::CFG_EXTRAPOLATE_ON: r_ext <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register: capture every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
        end
    end

    // blend factor in Q2.8: alpha, or one plus alpha when extrapolating
    assign t_fac = 10'(r_in.alpha) + (r_ext ? ssfi_pkg::ONE_Q8 : 10'd0);

    ssfi_gate u_gate (
        .i_item (r_in),
        .i_thr  (r_thr),
        .o_gate (gate)
    );

    ssfi_blend u_blend_x (
        .i_base  (r_in.prev_x),
        .i_delta (gate.dx),
        .i_t     (t_fac),
        .o_val   (blend_x)
    );

    ssfi_blend u_blend_y (
        .i_base  (r_in.prev_y),
        .i_delta (gate.dy),
        .i_t     (t_fac),
        .o_val   (blend_y)
    );

    // pick blended or current position; scroll drops tile and attribute
    always_comb begin
        n_out.out_x = gate.interp ? blend_x : r_in.cur_x;
        n_out.out_y = gate.interp ? blend_y : r_in.cur_y;
        if (r_in.command == ssfi_pkg::CMD_SCROLL) begin
            n_out.out_tile = 8'd0;
            n_out.out_attr = 8'd0;
        end else begin
            n_out.out_tile = r_in.cur_tile;
            n_out.out_attr = r_in.cur_attr;
        end
    end

    // result register: one-cycle strobe, no hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_done = r_out_vld;
    assign o_out  = r_out;

    // every result traces back to an accepted transaction, through the input and result registers
    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 2))
        else $error("result strobe without a matching transaction");

    // scroll results carry no tile or attribute
    a_scroll_zero_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_in.command, 2) == ssfi_pkg::CMD_SCROLL)
            |-> (o_out.out_tile == 8'd0 && o_out.out_attr == 8'd0))
        else $error("scroll result with nonzero tile or attribute");

    // without a previous frame the current position passes through
    a_no_prev_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !$past(i_in.prev_valid, 2))
            |-> (o_out.out_x == $past(i_in.cur_x, 2) && o_out.out_y == $past(i_in.cur_y, 2)))
        else $error("position changed with no previous frame");

    // sprite results pass the current tile through
    a_sprite_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_in.command, 2) == ssfi_pkg::CMD_SPRITE)
            |-> (o_out.out_tile == $past(i_in.cur_tile, 2)))
        else $error("sprite tile not passed through");

endmodule

[dv/tb.sv]
module tb;

    // Clock, reset and DUT ports; every input starts at a known value.
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    ssfi_pkg::t_in                   i_in = '0;
    logic                            o_done;
    ssfi_pkg::t_out                  o_out;
    logic                            i_cfg_we = 1'b0;
    logic [ssfi_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [ssfi_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the configuration registers, used by the blend predictor.
    logic [7:0] jump_thr = ssfi_pkg::JUMP_RESET;
    logic       extrap_en = 1'b0;

    // Expected presented slots, oldest first.
    ssfi_pkg::t_out slot_q[$];
    int             fail_cnt = 0;

    typedef struct {
        ssfi_pkg::t_in  item;
        bit             typed;
        ssfi_pkg::t_out result;
    } t_slot_row;

    t_slot_row  dir_rows[$];

    sprite_scroll_frame_interpolator_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the DUT hangs or stops producing results.
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Round half up of (a*256 + d*t)/256, then wrap to 8 bits. The bias is a
    // multiple of 65536 so the sum stays positive and bits [15:8] are unchanged.
    function automatic logic [7:0] blend_q8(int a, int d, int t);
        int v;
        v = a * 256 + d * t + 128 + 262144;
        return v[15:8];
    endfunction

    function automatic bit off_screen(logic [7:0] x, logic [7:0] y);
        return (y == 8'd0) || (y >= ssfi_pkg::OFFSCREEN_Y)
            || (x == 8'd0) || (x >= ssfi_pkg::OFFSCREEN_X);
    endfunction

    // Predict the presented slot for one transaction under the current shadow config.
    function automatic ssfi_pkg::t_out predict_slot(ssfi_pkg::t_in it);
        ssfi_pkg::t_out r;
        int   t, dx, dy, thr;
        t   = extrap_en ? 256 + int'(it.alpha) : int'(it.alpha);
        dx  = int'(it.cur_x) - int'(it.prev_x);
        dy  = int'(it.cur_y) - int'(it.prev_y);
        thr = int'(jump_thr);
        r.out_x = it.cur_x;
        r.out_y = it.cur_y;
        if (it.command == ssfi_pkg::CMD_SCROLL) begin
            r.out_tile = '0;
            r.out_attr = '0;
            if (!it.prev_valid)
                return r;
            // take the shortest way around the 256 wrap
            if (dx > 128) dx -= 256;
            if (dx < -128) dx += 256;
            if (dy > 128) dy -= 256;
            if (dy < -128) dy += 256;
            r.out_x = blend_q8(int'(it.prev_x), dx, t);
            r.out_y = blend_q8(int'(it.prev_y), dy, t);
            return r;
        end
        r.out_tile = it.cur_tile;
        r.out_attr = it.cur_attr;
        if (!it.prev_valid) return r;
        if (it.prev_tile != it.cur_tile || it.prev_attr != it.cur_attr) return r;
        if (off_screen(it.prev_x, it.prev_y) || off_screen(it.cur_x, it.cur_y)) return r;
        if (dx > thr || dx < -thr || dy > thr || dy < -thr) return r;
        r.out_x = blend_q8(int'(it.prev_x), dx, t);
        r.out_y = blend_q8(int'(it.prev_y), dy, t);
        return r;
    endfunction

    function automatic ssfi_pkg::t_in mk_slot(logic cmd, logic pv, int alpha,
                                              int px, int py, int pt, int pa,
                                              int cx, int cy, int ct, int ca);
        ssfi_pkg::t_in it;
        it.command    = cmd;
        it.prev_valid = pv;
        it.alpha      = 9'(alpha);
        it.prev_x     = 8'(px);
        it.prev_y     = 8'(py);
        it.prev_tile  = 8'(pt);
        it.prev_attr  = 8'(pa);
        it.cur_x      = 8'(cx);
        it.cur_y      = 8'(cy);
        it.cur_tile   = 8'(ct);
        it.cur_attr   = 8'(ca);
        return it;
    endfunction

    function automatic void add_row(ssfi_pkg::t_in it, bit typed, ssfi_pkg::t_out r);
        t_slot_row row;
        row.item   = it;
        row.typed  = typed;
        row.result = r;
        dir_rows.push_back(row);
    endfunction

    // Pick a current coordinate within the jump threshold of p, kept on screen.
    function automatic logic [7:0] near_coord(int p, int hi);
        int lo2, hi2;
        lo2 = (p - int'(jump_thr) < 1) ? 1 : p - int'(jump_thr);
        hi2 = (p + int'(jump_thr) > hi) ? hi : p + int'(jump_thr);
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 1) ? hi2 : lo2);
        return 8'($urandom_range(lo2, hi2));
    endfunction

    // Mostly well-formed sprite motion, plus scroll pairs, broken sprites and noise.
    function automatic ssfi_pkg::t_in random_slot();
        ssfi_pkg::t_in it;
        int  k;
        it = mk_slot(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0,
                     $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
        it.alpha = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(257, 511))
                                               : 9'($urandom_range(0, 256));
        k = $urandom_range(0, 99);
        if (k < 90 && !(k >= 60 && k < 80)) begin
            it.command    = ssfi_pkg::CMD_SPRITE;
            it.prev_valid = 1'b1;
            it.prev_tile  = it.cur_tile;
            it.prev_attr  = it.cur_attr;
            it.prev_x     = 8'($urandom_range(1, 167));
            it.prev_y     = 8'($urandom_range(1, 159));
            it.cur_x      = near_coord(int'(it.prev_x), 167);
            it.cur_y      = near_coord(int'(it.prev_y), 159);
            if (k >= 80) begin
                // break one interpolation condition
                case ($urandom_range(0, 4))
                    0: it.prev_valid = 1'b0;
                    1: it.cur_tile = it.cur_tile ^ 8'($urandom_range(1, 255));
                    2: it.cur_attr = it.cur_attr ^ 8'($urandom_range(1, 255));
                    3: it.cur_x = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(168, 255));
                    default: it.cur_y = it.prev_y + jump_thr + 8'd1;
                endcase
            end
        end else if (k < 80) begin
            it.command    = ssfi_pkg::CMD_SCROLL;
            it.prev_valid = ($urandom_range(0, 9) != 0);
        end
        return it;
    endfunction

    // Gap after a transaction: mostly none or short, now and then long.
    function automatic int pick_gap(bit idle_on);
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one transaction, hold it until accepted, then idle for the gap.
    task automatic send_slot(ssfi_pkg::t_in it, bit typed, ssfi_pkg::t_out r, int gap);
        i_in  <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        slot_q.push_back(typed ? r : predict_slot(it));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start and let every expected result come back, then a few spare cycles.
    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (slot_q.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    // Write the threshold register, then the extrapolation register; only called while the DUT is idle.
    task automatic set_config(logic [7:0] thr, logic ext);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ssfi_pkg::CFG_JUMP_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_idx  <= ssfi_pkg::CFG_EXTRAPOLATE_ON;
        i_cfg_data <= ssfi_pkg::CFG_DATA_W'(ext);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        jump_thr  = thr;
        extrap_en = ext;
    endtask

    // Result monitor: every strobe must match the oldest expected slot.
    always @(posedge i_clk) begin
        ssfi_pkg::t_out exp_slot;
        if (i_rst_n && o_done) begin
            if (slot_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d tile=%0d attr=%0d",
                         $time, o_out.out_x, o_out.out_y, o_out.out_tile, o_out.out_attr);
                fail_cnt++;
            end else begin
                exp_slot = slot_q.pop_front();
                if (o_out.out_x !== exp_slot.out_x) begin
                    $display("%0t: out_x expected %0d actual %0d",
                             $time, exp_slot.out_x, o_out.out_x);
                    fail_cnt++;
                end
                if (o_out.out_y !== exp_slot.out_y) begin
                    $display("%0t: out_y expected %0d actual %0d",
                             $time, exp_slot.out_y, o_out.out_y);
                    fail_cnt++;
                end
                if (o_out.out_tile !== exp_slot.out_tile) begin
                    $display("%0t: out_tile expected %0d actual %0d",
                             $time, exp_slot.out_tile, o_out.out_tile);
                    fail_cnt++;
                end
                if (o_out.out_attr !== exp_slot.out_attr) begin
                    $display("%0t: out_attr expected %0d actual %0d",
                             $time, exp_slot.out_attr, o_out.out_attr);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        logic [7:0] thr_set[6];
        logic       ext_set[6];
        bit         idle_on;

        // Directed table, run at the reset configuration (threshold 16, no
        // extrapolation). Typed rows carry a result readable at a glance.
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b0, 128, 40, 50, 9, 2, 44, 52, 9, 2),
                1, ssfi_pkg::t_out'{8'd44, 8'd52, 8'd9, 8'd2});     // no previous frame
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 128, 40, 50, 9, 2, 44, 52, 8, 2),
                1, ssfi_pkg::t_out'{8'd44, 8'd52, 8'd8, 8'd2});     // tile changed
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 128, 40, 50, 9, 2, 44, 52, 9, 3),
                1, ssfi_pkg::t_out'{8'd44, 8'd52, 8'd9, 8'd3});     // attribute changed
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 128, 0, 50, 9, 2, 4, 52, 9, 2),
                1, ssfi_pkg::t_out'{8'd4, 8'd52, 8'd9, 8'd2});      // previous x offscreen
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 128, 40, 0, 9, 2, 44, 4, 9, 2),
                1, ssfi_pkg::t_out'{8'd44, 8'd4, 8'd9, 8'd2});      // previous y offscreen
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 128, 160, 50, 9, 2, 168, 52, 9, 2),
                1, ssfi_pkg::t_out'{8'd168, 8'd52, 8'd9, 8'd2});    // current x at 168
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 128, 40, 155, 9, 2, 44, 160, 9, 2),
                1, ssfi_pkg::t_out'{8'd44, 8'd160, 8'd9, 8'd2});    // current y at 160
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 128, 40, 50, 9, 2, 57, 52, 9, 2),
                1, ssfi_pkg::t_out'{8'd57, 8'd52, 8'd9, 8'd2});     // x jump one past threshold
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 128, 40, 50, 9, 2, 44, 33, 9, 2),
                1, ssfi_pkg::t_out'{8'd44, 8'd33, 8'd9, 8'd2});     // y jump one past threshold
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 0, 40, 50, 9, 2, 56, 34, 9, 2),
                1, ssfi_pkg::t_out'{8'd40, 8'd50, 8'd9, 8'd2});     // alpha 0 gives previous
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 256, 40, 50, 9, 2, 56, 34, 9, 2),
                1, ssfi_pkg::t_out'{8'd56, 8'd34, 8'd9, 8'd2});     // alpha 1.0 gives current
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 128, 167, 159, 255, 255,
                        151, 143, 255, 255), 0, '0);
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 128, 50, 50, 0, 0, 51, 49, 0, 0), 0, '0);
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 511, 100, 100, 1, 1, 116, 84, 1, 1),
                0, '0);
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 1, 1, 1, 7, 7, 17, 17, 7, 7), 0, '0);
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b1, 511, 255, 255, 255, 255,
                        255, 255, 255, 255),
                1, ssfi_pkg::t_out'{8'd255, 8'd255, 8'd255, 8'd255});
        add_row(mk_slot(ssfi_pkg::CMD_SPRITE, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1, ssfi_pkg::t_out'{8'd0, 8'd0, 8'd0, 8'd0});
        add_row(mk_slot(ssfi_pkg::CMD_SCROLL, 1'b0, 128, 10, 20, 33, 44, 200, 210, 55, 66),
                1, ssfi_pkg::t_out'{8'd200, 8'd210, 8'd0, 8'd0});   // scroll, no previous frame
        add_row(mk_slot(ssfi_pkg::CMD_SCROLL, 1'b1, 0, 10, 20, 33, 44, 200, 210, 55, 66),
                1, ssfi_pkg::t_out'{8'd10, 8'd20, 8'd0, 8'd0});
        add_row(mk_slot(ssfi_pkg::CMD_SCROLL, 1'b1, 256, 250, 5, 0, 0, 5, 250, 0, 0),
                1, ssfi_pkg::t_out'{8'd5, 8'd250, 8'd0, 8'd0});     // shortest path across wrap
        add_row(mk_slot(ssfi_pkg::CMD_SCROLL, 1'b1, 128, 0, 128, 0, 0, 128, 0, 0, 0), 0, '0);
        add_row(mk_slot(ssfi_pkg::CMD_SCROLL, 1'b1, 128, 0, 0, 0, 0, 129, 127, 0, 0), 0, '0);
        add_row(mk_slot(ssfi_pkg::CMD_SCROLL, 1'b1, 511, 255, 255, 255, 255,
                        255, 255, 255, 255), 0, '0);

        // Random phases walk through the register extremes and a few random settings.
        thr_set = '{8'd0, 8'd255, 8'd255, 8'd0, 8'($urandom), 8'($urandom_range(4, 40))};
        ext_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom), 1'b1};

        // Hold reset low from time zero, then release it once.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b1;
        foreach (dir_rows[i])
            send_slot(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result,
                      pick_gap(idle_on));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_config(thr_set[ph], ext_set[ph]);
            // alternate between bursty traffic and back-to-back streaming
            idle_on = (ph % 2 == 0);
            for (int n = 0; n < 100; n++)
                send_slot(random_slot(), 0, '0, pick_gap(idle_on));
            drain();
        end

        if (slot_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, slot_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
src/ssfi_pkg.sv
src/ssfi_gate.sv
src/ssfi_blend.sv
src/sprite_scroll_frame_interpolator_unit.sv
dv/tb.sv
